>>> hw/rtl/ship_dip_rrip_replacement_assert.svh
// ----------------------------------------------------------------------------
// ship_dip_rrip_replacement assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SHIP_DIP_RRIP_REPLACEMENT_ASSERT_SVH
`define SHIP_DIP_RRIP_REPLACEMENT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, property given whole
`define SDRR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle, consequence in the next
`define SDRR_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define SDRR_ASSERT(name, clk, rst_n, prop, msg)
`define SDRR_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

>>> hw/rtl/sdrr_pkg.sv
// ----------------------------------------------------------------------------
// sdrr_pkg
// field widths, policy constants and request codes of the replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package sdrr_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned SetIdxW  = 11;
  localparam int unsigned WayW     = 4;
  localparam int unsigned SigW     = 6;
  localparam int unsigned DrawW    = 5;
  localparam int unsigned RrpvBits = 2;
  localparam int unsigned CntW     = 2;
  localparam int unsigned PselW    = 10;

  // every signature value the port can carry
  localparam int unsigned SigSpan  = 64;

  localparam logic [RrpvBits-1:0] RrpvNear = 2'd0;
  localparam logic [RrpvBits-1:0] RrpvLong = 2'd2;
  localparam logic [RrpvBits-1:0] RrpvMax  = 2'd3;

  localparam logic [CntW-1:0] CntZero  = 2'd0;
  localparam logic [CntW-1:0] CntReset = 2'd1;
  localparam logic [CntW-1:0] CntMax   = 2'd3;

  localparam logic [PselW-1:0] PselMid = 10'd512;
  localparam logic [PselW-1:0] PselMax = 10'd1023;

  localparam int unsigned LeaderStride = 17;
  localparam int unsigned LeaderOffset = 7;

  typedef enum logic [ActionW-1:0] {
    ACT_VICTIM = 2'd0,
    ACT_HIT    = 2'd1,
    ACT_FILL   = 2'd2
  } action_e;

endpackage

`default_nettype wire

>>> hw/rtl/sdrr_if.sv
// ----------------------------------------------------------------------------
// sdrr_if
// request and victim-result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sdrr_req_if import sdrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [SetIdxW-1:0] set_index;
  logic [WayW-1:0]    way;
  logic [SigW-1:0]    signature;
  logic [DrawW-1:0]   random_draw;

  modport source (
    output valid, action, set_index, way, signature, random_draw,
    input  ready
  );
  modport sink (
    input  valid, action, set_index, way, signature, random_draw,
    output ready
  );
endinterface

interface sdrr_rsp_if import sdrr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WayW-1:0] victim_way;

  modport source (
    output valid, victim_way,
    input  ready
  );
  modport sink (
    input  valid, victim_way,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/sdrr_age_pick.sv
// ----------------------------------------------------------------------------
// sdrr_age_pick
// ages a set so its oldest way reaches the distant value and picks the lowest
// such way as victim
// ----------------------------------------------------------------------------
`default_nettype none

module sdrr_age_pick import sdrr_pkg::*; #(
  parameter int unsigned WAY_COUNT = 16
) (
  input  logic [RrpvBits*WAY_COUNT-1:0] rrpv_i,
  output logic [RrpvBits*WAY_COUNT-1:0] aged_o,
  output logic [WayW-1:0]               victim_o
);

  logic [WAY_COUNT-1:0] at3, at2, at1;
  logic [RrpvBits-1:0]  top;
  logic [RrpvBits-1:0]  add;

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      at3[w] = (rrpv_i[RrpvBits*w +: RrpvBits] == 2'd3);
      at2[w] = (rrpv_i[RrpvBits*w +: RrpvBits] == 2'd2);
      at1[w] = (rrpv_i[RrpvBits*w +: RrpvBits] == 2'd1);
    end
  end

  always_comb begin
    priority if (|at3) begin
      top = 2'd3;
    end else if (|at2) begin
      top = 2'd2;
    end else if (|at1) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
  end

  assign add = RrpvMax - top;

  // no way exceeds top, so the add never wraps
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      aged_o[RrpvBits*w +: RrpvBits] = rrpv_i[RrpvBits*w +: RrpvBits] + add;
    end
  end

  // lowest way at the distant value wins
  always_comb begin
    victim_o = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (aged_o[RrpvBits*w +: RrpvBits] == RrpvMax) begin
        victim_o = WayW'(w);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ship_dip_rrip_replacement.sv
// ----------------------------------------------------------------------------
// ship_dip_rrip_replacement
// Last-level-cache replacement: SRRIP ageing, signature reuse prediction for
// insertion, LIP/BIP set dueling for cold signatures.
//
// req_i takes one beat per request: victim query, hit update or fill. Only a
// victim query returns a beat on rsp_o, carrying the way to evict.
// Per-set RRPVs and line signatures share one row of a single-port set memory;
// the reuse counters sit in a small memory with one valid bit per entry.
// A victim query or a hit is a row read, then a modify and write back; a
// fill adds a second counter read for the evicted line's signature before
// its write back. A hit or fill naming a way not below WAY_COUNT, or an
// unused action code, is accepted and does nothing.
// The victim beat leaves from an output register loaded at write-back. While
// rsp_o is stalled with a result, a further victim query waits in its
// write-back cycle and req_i holds ready low; other requests pass.
// After reset a clearing pass writes every set row, one per cycle; req_i
// holds ready low until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ship_dip_rrip_replacement_assert.svh"

module ship_dip_rrip_replacement import sdrr_pkg::*; #(
  parameter int unsigned SET_COUNT         = 2048,
  parameter int unsigned WAY_COUNT         = 16,
  parameter int unsigned SIGNATURE_ENTRIES = 64,
  parameter int unsigned LEADER_COUNT      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdrr_req_if.sink    req_i,
  sdrr_rsp_if.source  rsp_o
);

  localparam int unsigned SetW     = $clog2(SET_COUNT);
  localparam int unsigned SetCmpW  = (SetW + 1 > SetIdxW) ? SetW + 1 : SetIdxW;
  localparam int unsigned WayIdxW  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned WayCmpW  = WayW + 1;
  localparam int unsigned RrpvVecW = RrpvBits * WAY_COUNT;
  localparam int unsigned SigVecW  = SigW * WAY_COUNT;
  localparam int unsigned RowW     = RrpvVecW + SigVecW;
  localparam int unsigned CntDepth = (SIGNATURE_ENTRIES < SigSpan) ? SIGNATURE_ENTRIES : SigSpan;
  localparam int unsigned CntIdxW  = $clog2(CntDepth);
  localparam int unsigned ModW     = ($clog2(SIGNATURE_ENTRIES) + 1 > SigW)
                                     ? $clog2(SIGNATURE_ENTRIES) + 1 : SigW + 1;
  localparam int unsigned ModSteps = 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  function automatic logic [CntIdxW-1:0] sig_index(input logic [SigW-1:0] sig);
    logic [ModW-1:0] v;
    v = ModW'(sig);
    for (int k = 0; k < ModSteps; k++) begin
      if (v >= ModW'(SIGNATURE_ENTRIES)) begin
        v = v - ModW'(SIGNATURE_ENTRIES);
      end
    end
    return v[CntIdxW-1:0];
  endfunction

  // request decode
  logic [SetCmpW-1:0] set_ext, set_red;
  logic [SetW-1:0]    req_set;
  logic               req_fire, req_work, way_ok;

  assign set_ext = SetCmpW'(req_i.set_index);
  assign set_red = (set_ext >= SetCmpW'(SET_COUNT)) ? set_ext - SetCmpW'(SET_COUNT) : set_ext;
  assign req_set = set_red[SetW-1:0];
  assign way_ok  = ({1'b0, req_i.way} < WayCmpW'(WAY_COUNT));
  assign req_work = (req_i.action == ACT_VICTIM) ||
                    (((req_i.action == ACT_HIT) || (req_i.action == ACT_FILL)) && way_ok);

  logic [1:0] state_q, state_d;
  logic       clr_busy_q;
  logic [SetW-1:0] clr_addr_q;

  assign req_i.ready = (state_q == S_IDLE) && !clr_busy_q;
  assign req_fire    = req_i.valid && req_i.ready;

  // request registers
  action_e             act_q;
  logic [SetW-1:0]     set_q;
  logic [WayIdxW-1:0]  way_q;
  logic [SigW-1:0]     sig_q;
  logic [CntIdxW-1:0]  sig_idx_q;
  logic [DrawW-1:0]    draw_q;
  logic [CntIdxW-1:0]  old_idx_q;
  logic [CntW-1:0]     cnt_new_q;

  always_ff @(posedge clk_i) begin
    if (req_fire && req_work) begin
      act_q     <= action_e'(req_i.action);
      set_q     <= req_set;
      way_q     <= req_i.way[WayIdxW-1:0];
      sig_q     <= req_i.signature;
      sig_idx_q <= sig_index(req_i.signature);
      draw_q    <= req_i.random_draw;
    end
  end

  // set memory: {signatures, rrpvs} per set
  logic [RowW-1:0] row_mem [SET_COUNT];
  logic [RowW-1:0] row_rd_q, row_wdata;
  logic [SetW-1:0] row_waddr;
  logic            row_we;

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (req_fire && req_work) begin
      row_rd_q <= row_mem[req_set];
    end
  end

  // reuse counter memory, unwritten entries read as the reset count
  logic [CntW-1:0]    cnt_mem [CntDepth];
  logic [CntDepth-1:0] cnt_vld_q;
  logic [CntW-1:0]    cnt_rd_q, cnt_rd_val, cnt_wdata;
  logic               cnt_rd_vld_q;
  logic [CntIdxW-1:0] cnt_raddr, cnt_waddr;
  logic               cnt_re, cnt_we;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      cnt_rd_vld_q <= 1'b0;
    end else begin
      if (cnt_re) begin
        cnt_rd_vld_q <= cnt_vld_q[cnt_raddr];
      end
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
    end
  end

  assign cnt_rd_val = cnt_rd_vld_q ? cnt_rd_q : CntReset;

  // row fields of the addressed set
  logic [RrpvVecW-1:0] rrpv_rd, aged;
  logic [SigVecW-1:0]  sigs_rd;
  logic [SigW-1:0]     old_sig;
  logic [CntIdxW-1:0]  old_idx;
  logic [WayW-1:0]     victim;

  assign rrpv_rd = row_rd_q[RrpvVecW-1:0];
  assign sigs_rd = row_rd_q[RowW-1:RrpvVecW];
  assign old_sig = sigs_rd[SigW*way_q +: SigW];
  assign old_idx = sig_index(old_sig);

  sdrr_age_pick #(
    .WAY_COUNT (WAY_COUNT)
  ) u_age_pick (
    .rrpv_i   (rrpv_rd),
    .aged_o   (aged),
    .victim_o (victim)
  );

  assign cnt_re    = (req_fire && req_work) || ((state_q == S_READ) && (act_q == ACT_FILL));
  assign cnt_raddr = (state_q == S_IDLE) ? sig_index(req_i.signature) : old_idx;

  // leader sets
  logic [LEADER_COUNT-1:0] lip_match, bip_match;
  logic                    lip_lead, bip_lead, choose_lip;

  for (genvar g = 0; g < LEADER_COUNT; g++) begin : g_leader
    localparam int unsigned LipSet = (g * LeaderStride) % SET_COUNT;
    localparam int unsigned BipSet = (g * LeaderStride + LeaderOffset) % SET_COUNT;
    assign lip_match[g] = (set_q == SetW'(LipSet));
    assign bip_match[g] = (set_q == SetW'(BipSet));
  end

  assign lip_lead = |lip_match;
  assign bip_lead = |bip_match;

  logic psel_lip;
  logic [PselW-1:0] psel_q, psel_d, psel_up;

  assign psel_lip = (psel_q < PselMid);

  // lowest leader index decides, lip first at a tie; other sets use psel
  always_comb begin
    choose_lip = psel_lip;
    for (int i = LEADER_COUNT - 1; i >= 0; i--) begin
      if (bip_match[i]) begin
        choose_lip = 1'b0;
      end
      if (lip_match[i]) begin
        choose_lip = 1'b1;
      end
    end
  end

  assign psel_up = (lip_lead && (psel_q != PselMax)) ? psel_q + PselW'(1) : psel_q;

  // fill arithmetic
  logic [CntW-1:0]     cnt_dec, cnt_use, cnt_inc;
  logic [RrpvBits-1:0] ins;

  assign cnt_inc = (cnt_rd_val == CntMax) ? cnt_rd_val : cnt_rd_val + CntW'(1);
  assign cnt_dec = (cnt_rd_val == CntZero) ? cnt_rd_val : cnt_rd_val - CntW'(1);
  // the evicted line's counter may be the one that steers insertion
  assign cnt_use = (old_idx_q == sig_idx_q) ? cnt_dec : cnt_new_q;

  always_comb begin
    priority if (cnt_use[1]) begin
      ins = RrpvNear;
    end else if (cnt_use == CntReset) begin
      ins = RrpvLong;
    end else if (choose_lip) begin
      ins = RrpvMax;
    end else if (draw_q == '0) begin
      ins = RrpvNear;
    end else begin
      ins = RrpvMax;
    end
  end

  // output register
  logic            rsp_valid_q, out_free, out_load;
  logic [WayW-1:0] victim_q;

  assign out_free         = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.victim_way = victim_q;

  // control and write-back
  logic [RrpvVecW-1:0] rrpv_mod;
  logic [SigVecW-1:0]  sigs_mod;

  always_comb begin
    state_d   = state_q;
    row_we    = 1'b0;
    row_waddr = set_q;
    row_wdata = row_rd_q;
    cnt_we    = 1'b0;
    cnt_waddr = sig_idx_q;
    cnt_wdata = cnt_inc;
    psel_d    = psel_q;
    out_load  = 1'b0;
    rrpv_mod  = rrpv_rd;
    sigs_mod  = sigs_rd;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire && req_work) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        unique case (act_q)
          ACT_VICTIM: begin
            if (out_free) begin
              row_we    = 1'b1;
              row_wdata = {sigs_rd, aged};
              out_load  = 1'b1;
              state_d   = S_IDLE;
            end
          end
          ACT_HIT: begin
            rrpv_mod[RrpvBits*way_q +: RrpvBits] = RrpvNear;
            row_we    = 1'b1;
            row_wdata = {sigs_rd, rrpv_mod};
            cnt_we    = 1'b1;
            state_d   = S_IDLE;
          end
          ACT_FILL: begin
            state_d = S_FILL;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        rrpv_mod[RrpvBits*way_q +: RrpvBits] = ins;
        sigs_mod[SigW*way_q +: SigW]         = sig_q;
        row_we    = 1'b1;
        row_wdata = {sigs_mod, rrpv_mod};
        cnt_we    = 1'b1;
        cnt_waddr = old_idx_q;
        cnt_wdata = cnt_dec;
        psel_d    = (bip_lead && (psel_up != '0)) ? psel_up - PselW'(1) : psel_up;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // clearing pass owns the write port
    if (clr_busy_q) begin
      row_we    = 1'b1;
      row_waddr = clr_addr_q;
      row_wdata = {{SigVecW{1'b0}}, {RrpvVecW{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      old_idx_q <= old_idx;
      cnt_new_q <= cnt_rd_val;
    end
    if (out_load) begin
      victim_q <= victim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      psel_q      <= PselMid;
      rsp_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      state_q <= state_d;
      psel_q  <= psel_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + SetW'(1);
        if (clr_addr_q == SetW'(SET_COUNT - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  `SDRR_ASSERT(a_clr_blocks_req, clk_i, rst_ni, clr_busy_q |-> !req_i.ready, "request beat during clearing pass")
  `SDRR_ASSERT(a_cnt_write_state, clk_i, rst_ni, cnt_we |-> (state_q == S_READ || state_q == S_FILL), "counter write outside an update step")
  `SDRR_ASSERT(a_rsp_from_query, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q == S_READ && act_q == ACT_VICTIM), "result beat without a victim query")
  `SDRR_ASSERT_NEXT(a_fill_second_read, clk_i, rst_ni, state_q == S_READ && act_q == ACT_FILL, state_q == S_FILL, "fill skipped its counter step")
  `SDRR_ASSERT(a_psel_on_fill, clk_i, rst_ni, !$stable(psel_q) |-> $past(state_q == S_FILL), "selector moved outside a fill")

endmodule

`default_nettype wire
